>>> src/usc_pkg.sv
// ----------------------------------------------------------------------------
// usc_pkg
// types, constants and calendar tables shared by the seconds-to-calendar unit
// ----------------------------------------------------------------------------
package usc_pkg;

  localparam int unsigned StampW = 32;
  localparam int unsigned DaysW  = 16;
  localparam int unsigned YearW  = 12;
  localparam int unsigned PcW    = 4;

  localparam logic [YearW-1:0] EpochYear    = 12'd1970;
  localparam logic [2:0]       EpochWeekday = 3'd4;
  localparam logic [3:0]       LastMonth    = 4'd11;

  // reciprocals for the constant divides, exact over the operand ranges used
  localparam logic [25:0] RecipDay  = 26'd50903317;
  localparam logic [13:0] RecipHour = 14'd9321;
  localparam logic [10:0] RecipMin  = 11'd1093;
  localparam logic [16:0] RecipWeek = 17'd74899;

  typedef enum logic [3:0] {
    OP_IDLE  = 4'd0,
    OP_DIV   = 4'd1,
    OP_DAYS  = 4'd2,
    OP_HOURS = 4'd3,
    OP_MINS  = 4'd4,
    OP_WDAY  = 4'd5,
    OP_YEAR  = 4'd6,
    OP_MONTH = 4'd7,
    OP_EMIT  = 4'd8,
    OP_NOP   = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    DV_DAY  = 2'd0,
    DV_HOUR = 2'd1,
    DV_MIN  = 2'd2,
    DV_WEEK = 2'd3
  } dvs_t;

  typedef enum logic [2:0] {
    COND_NEVER    = 3'd0,
    COND_ALWAYS   = 3'd1,
    COND_NO_BEAT  = 3'd2,
    COND_FITS     = 3'd3,
    COND_OUT_BUSY = 3'd4
  } cond_t;

  typedef struct packed {
    op_t             op;
    dvs_t            dvs;
    cond_t           cond;
    logic [PcW-1:0]  target;
  } cw_t;

  typedef struct packed {
    logic taken;
    logic fits;
    logic out_busy;
  } status_t;

  function automatic logic [16:0] divisor(input dvs_t d);
    logic [16:0] v;
    unique case (d)
      DV_DAY:  v = 17'd86400;
      DV_HOUR: v = 17'd3600;
      DV_MIN:  v = 17'd60;
      DV_WEEK: v = 17'd7;
      default: v = 17'd7;
    endcase
    return v;
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? 9'd366 : 9'd365;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] v;
    unique case (m)
      4'd1:                         v = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:      v = 5'd30;
      default:                      v = 5'd31;
    endcase
    return v;
  endfunction

endpackage

>>> src/usc_if.sv
// ----------------------------------------------------------------------------
// usc channel interfaces
// valid/ready channels for timestamp beats and calendar beats
// ----------------------------------------------------------------------------
interface usc_in_if
  import usc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [StampW-1:0] timestamp;

  modport source (output valid, output timestamp, input ready);
  modport sink   (input valid, input timestamp, output ready);
endinterface

interface usc_out_if
  import usc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [5:0]       seconds;
  logic [5:0]       minutes;
  logic [4:0]       hours;
  logic [2:0]       weekday;
  logic [YearW-1:0] year;
  logic [3:0]       month;
  logic [4:0]       day_of_month;

  modport source (output valid, output seconds, output minutes, output hours,
                  output weekday, output year, output month, output day_of_month,
                  input ready);
  modport sink   (input valid, input seconds, input minutes, input hours,
                  input weekday, input year, input month, input day_of_month,
                  output ready);
endinterface

>>> src/usc_seq.sv
// ----------------------------------------------------------------------------
// usc_seq
// microcode store and step counter with conditional jumps
// ----------------------------------------------------------------------------
module usc_seq
  import usc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output cw_t     cw
);

  localparam logic [PcW-1:0] StIdle  = 4'd0;
  localparam logic [PcW-1:0] StYear  = 4'd9;
  localparam logic [PcW-1:0] StMonth = 4'd10;
  localparam logic [PcW-1:0] StEmit  = 4'd11;

  logic [PcW-1:0] pc;
  logic [PcW-1:0] pc_next;
  logic           jump;

  function automatic cw_t rom_word(input logic [PcW-1:0] a);
    cw_t w;
    unique case (a)
      4'd0:    w = '{OP_IDLE,  DV_DAY,  COND_NO_BEAT,  StIdle};
      4'd1:    w = '{OP_DIV,   DV_DAY,  COND_NEVER,    StIdle};
      4'd2:    w = '{OP_DAYS,  DV_DAY,  COND_NEVER,    StIdle};
      4'd3:    w = '{OP_DIV,   DV_HOUR, COND_NEVER,    StIdle};
      4'd4:    w = '{OP_HOURS, DV_HOUR, COND_NEVER,    StIdle};
      4'd5:    w = '{OP_DIV,   DV_MIN,  COND_NEVER,    StIdle};
      4'd6:    w = '{OP_MINS,  DV_MIN,  COND_NEVER,    StIdle};
      4'd7:    w = '{OP_DIV,   DV_WEEK, COND_NEVER,    StIdle};
      4'd8:    w = '{OP_WDAY,  DV_WEEK, COND_NEVER,    StIdle};
      4'd9:    w = '{OP_YEAR,  DV_DAY,  COND_FITS,     StYear};
      4'd10:   w = '{OP_MONTH, DV_DAY,  COND_FITS,     StMonth};
      4'd11:   w = '{OP_EMIT,  DV_DAY,  COND_OUT_BUSY, StEmit};
      default: w = '{OP_NOP,   DV_DAY,  COND_ALWAYS,   StIdle};
    endcase
    return w;
  endfunction

  assign cw = rom_word(pc);

  always_comb begin
    unique case (cw.cond)
      COND_NEVER:    jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_BEAT:  jump = !status.taken;
      COND_FITS:     jump = status.fits;
      COND_OUT_BUSY: jump = status.out_busy;
      default:       jump = 1'b1;
    endcase
    pc_next = jump ? cw.target : pc + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= StIdle;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> src/usc_dp.sv
// ----------------------------------------------------------------------------
// usc_dp
// datapath: reciprocal-multiply divider, year and month walk, result register
// ----------------------------------------------------------------------------
module usc_dp
  import usc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cw_t          cw,
  output status_t      status,
  usc_in_if.sink       stamp,
  usc_out_if.source    cal
);

  logic [StampW-1:0] acc;
  logic [DaysW-1:0]  quo;
  logic [DaysW-1:0]  days;
  logic [4:0]        hours;
  logic [5:0]        minutes;
  logic [5:0]        seconds;
  logic [2:0]        weekday;
  logic [YearW-1:0]  year;
  logic [1:0]        c4;
  logic [6:0]        c100;
  logic [8:0]        c400;
  logic [3:0]        mon;
  logic              out_valid;

  logic              leap;
  logic [50:0]       q_day;
  logic [26:0]       q_hour;
  logic [20:0]       q_min;
  logic [32:0]       q_week;
  logic [DaysW-1:0]  quo_div;
  logic [32:0]       prod;
  logic [StampW-1:0] rem;
  logic [8:0]        ylen;
  logic [4:0]        mlen;
  logic              year_fits;
  logic              month_fits;

  assign leap       = ((c4 == 2'd0) && (c100 != 7'd0)) || (c400 == 9'd0);
  assign q_day      = {26'd0, acc[StampW-1:7]} * {25'd0, RecipDay};
  assign q_hour     = {14'd0, acc[16:4]} * {13'd0, RecipHour};
  assign q_min      = {11'd0, acc[11:2]} * {10'd0, RecipMin};
  assign q_week     = {17'd0, acc[15:0]} * {16'd0, RecipWeek};
  assign prod       = {17'd0, quo} * {16'd0, divisor(cw.dvs)};
  assign rem        = acc - prod[StampW-1:0];
  assign ylen       = year_len(leap);
  assign mlen       = month_len(mon, leap);
  assign year_fits  = acc >= {23'd0, ylen};
  assign month_fits = (mon != LastMonth) && (acc >= {27'd0, mlen});

  always_comb begin
    unique case (cw.dvs)
      DV_DAY:  quo_div = q_day[50:35];
      DV_HOUR: quo_div = {10'd0, q_hour[26:21]};
      DV_MIN:  quo_div = {9'd0, q_min[20:14]};
      DV_WEEK: quo_div = {2'd0, q_week[32:19]};
    endcase
  end

  assign stamp.ready = (cw.op == OP_IDLE) && !rst;

  assign status.taken    = stamp.ready && stamp.valid;
  assign status.fits     = ((cw.op == OP_YEAR) && year_fits) ||
                           ((cw.op == OP_MONTH) && month_fits);
  assign status.out_busy = out_valid && !cal.ready;

  assign cal.valid = out_valid;

  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_IDLE: begin
        if (status.taken) begin
          acc <= stamp.timestamp;
        end
      end
      OP_DIV: begin
        quo <= quo_div;
      end
      OP_DAYS: begin
        days <= quo;
        acc  <= rem;
      end
      OP_HOURS: begin
        hours <= quo[4:0];
        acc   <= rem;
      end
      OP_MINS: begin
        minutes <= quo[5:0];
        seconds <= rem[5:0];
        acc     <= {16'd0, days} + {29'd0, EpochWeekday};
      end
      OP_WDAY: begin
        weekday <= rem[2:0];
        acc     <= {16'd0, days};
        year    <= EpochYear;
        c4      <= 2'd2;
        c100    <= 7'd70;
        c400    <= 9'd370;
        mon     <= '0;
      end
      OP_YEAR: begin
        if (year_fits) begin
          acc  <= acc - {23'd0, ylen};
          year <= year + 12'd1;
          c4   <= c4 + 2'd1;
          c100 <= (c100 == 7'd99)  ? 7'd0 : c100 + 7'd1;
          c400 <= (c400 == 9'd399) ? 9'd0 : c400 + 9'd1;
        end
      end
      OP_MONTH: begin
        if (month_fits) begin
          acc <= acc - {27'd0, mlen};
          mon <= mon + 4'd1;
        end
      end
      OP_EMIT: begin
        if (!status.out_busy) begin
          cal.seconds      <= seconds;
          cal.minutes      <= minutes;
          cal.hours        <= hours;
          cal.weekday      <= weekday;
          cal.year         <= year;
          cal.month        <= mon + 4'd1;
          cal.day_of_month <= acc[4:0] + 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cw.op == OP_EMIT) && !status.out_busy) begin
      out_valid <= 1'b1;
    end else if (cal.ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

>>> src/unix_seconds_to_calendar_unit.sv
// conversion time from timestamp beat to calendar beat grows with the years past
//   1970 and the months walked, plus any calendar-side stall
// throughput: one timestamp beat per conversion, the next beat is taken only after
//   the result is loaded into the output register and a no-op step returns to idle
// the year walk, one year per cycle, sets most of the spread of the conversion time
// reset clears the step counter and the output valid, no clearing pass
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar_unit
// unix seconds to gregorian date and time, run by a small microcode program
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar_unit
  import usc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  usc_in_if.sink    stamp,
  usc_out_if.source cal
);

  cw_t     cw;
  status_t status;

  usc_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cw     (cw)
  );

  usc_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cw     (cw),
    .status (status),
    .stamp  (stamp),
    .cal    (cal)
  );

endmodule
